>>> hdl/grid_cell_occupancy_update_defines.svh
// Assertion macros for the grid cell occupancy update block.
`ifndef GRID_CELL_OCCUPANCY_UPDATE_DEFINES_SVH
`define GRID_CELL_OCCUPANCY_UPDATE_DEFINES_SVH

`ifndef SYNTH
`define GCOU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GCOU_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define GCOU_ASSERT(lbl, clk, rst_n, prop, msg)
`define GCOU_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

>>> hdl/gcou_pkg.sv
// Shared constants, types and state codes of the grid cell occupancy update block.
package gcou_pkg;

    localparam int MAX_OBJECTS = 64;
    localparam int GRID_CELLS  = 256;
    localparam int FRAC_BITS   = 8;

    localparam int ID_W        = $clog2(MAX_OBJECTS);
    localparam int CELL_W      = $clog2(GRID_CELLS);
    localparam int OCC_W       = MAX_OBJECTS;
    localparam int POS_W       = 16;
    localparam int HALF_W      = 11;
    localparam int COORD_W     = 18;
    localparam int IDX_W       = COORD_W - FRAC_BITS;
    localparam int GCOORD_W    = 4;
    localparam int MUL_W       = 9;
    localparam int CFG_W       = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int GRID_MAX    = 16;
    localparam int LIST_LEN    = 4;
    localparam int LIST_CNT_W  = 3;
    localparam int ENT_LIST_W  = LIST_CNT_W + LIST_LEN * CELL_W;
    localparam int EV_W        = 2 * LIST_LEN;
    localparam int EV_IDX_W    = 3;
    localparam int STEP_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] S_IDLE = 3'd0;
    localparam logic [STATE_W-1:0] S_CALC = 3'd1;
    localparam logic [STATE_W-1:0] S_MASK = 3'd2;
    localparam logic [STATE_W-1:0] S_EVRD = 3'd3;
    localparam logic [STATE_W-1:0] S_EVWR = 3'd4;

    typedef logic [CELL_W-1:0] t_cell;
    typedef logic [ID_W-1:0]   t_id;

endpackage

>>> hdl/gcou_in_if.sv
// Input channel: entity id with box centre and half extents.
interface gcou_in_if;
    logic                           valid;
    logic                           ready;
    gcou_pkg::t_id                  object_id;
    logic signed [gcou_pkg::POS_W-1:0] centre_x;
    logic signed [gcou_pkg::POS_W-1:0] centre_z;
    logic [gcou_pkg::HALF_W-1:0]    half_extent_x;
    logic [gcou_pkg::HALF_W-1:0]    half_extent_z;

    modport source (output valid, object_id, centre_x, centre_z, half_extent_x,
                    half_extent_z, input ready);
    modport sink   (input valid, object_id, centre_x, centre_z, half_extent_x,
                    half_extent_z, output ready);
endinterface

>>> hdl/gcou_out_if.sv
// Output channel: one cell enter or leave event.
interface gcou_out_if;
    logic            valid;
    logic            ready;
    gcou_pkg::t_cell cell_number;
    logic            entered;
    gcou_pkg::t_id   mover_id;
    logic            last_event;

    modport source (output valid, cell_number, entered, mover_id, last_event, input ready);
    modport sink   (input valid, cell_number, entered, mover_id, last_event, output ready);
endinterface

>>> hdl/gcou_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gcou_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/grid_cell_occupancy_update.sv
// Top level of the grid cell occupancy update block.
// Takes one entity beat at a time, maps its four box corners to grid cells through one
// shared coordinate adder/clamp and one shared cell multiplier, compares the distinct
// cells with the entity's stored list and emits one beat per cell left or entered,
// leaves first. An item of E events (0 to 8) is handled in steps: accept, eight
// sequencer steps for the four coordinates and four corners, the change masks, then
// a read-modify-write of the occupancy RAM per event, split into a read state and a
// write state. Ready is high only between items.
// Event beats wait in an output register; the sequencer holds while it is full.
// Occupancy words and entity lists come out of reset clear through per-entry valid
// bits, so there is no clearing pass.
`include "grid_cell_occupancy_update_defines.svh"

module grid_cell_occupancy_update (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gcou_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gcou_pkg::CFG_W-1:0]         i_cfg_data,
    gcou_in_if.sink                            i_in,
    gcou_out_if.source                         o_out
);

    logic [gcou_pkg::STATE_W-1:0]    r_state;
    logic [gcou_pkg::STEP_W-1:0]     r_step;
    logic [gcou_pkg::CFG_W-1:0]      r_grid_w;
    logic [gcou_pkg::CFG_W-1:0]      r_grid_h;
    logic [gcou_pkg::MAX_OBJECTS-1:0] r_ent_vld;
    logic [gcou_pkg::GRID_CELLS-1:0] r_occ_vld;
    logic                            r_old_vld;
    logic                            r_occ_hit;

    gcou_pkg::t_id                   r_id;
    logic signed [gcou_pkg::POS_W-1:0] r_cx;
    logic signed [gcou_pkg::POS_W-1:0] r_cz;
    logic [gcou_pkg::HALF_W-1:0]     r_hx;
    logic [gcou_pkg::HALF_W-1:0]     r_hz;
    logic [gcou_pkg::GCOORD_W-1:0]   r_coord [gcou_pkg::LIST_LEN];
    gcou_pkg::t_cell                 r_nw [gcou_pkg::LIST_LEN];
    logic [gcou_pkg::LIST_CNT_W-1:0] r_nn;
    gcou_pkg::t_cell                 r_old [gcou_pkg::LIST_LEN];
    logic [gcou_pkg::LIST_CNT_W-1:0] r_old_cnt;
    logic [gcou_pkg::EV_W-1:0]       r_ev_mask;
    gcou_pkg::t_cell                 r_cell;
    logic                            r_set;

    logic                            r_out_vld;
    gcou_pkg::t_cell                 r_out_cell;
    logic                            r_out_entered;
    gcou_pkg::t_id                   r_out_id;
    logic                            r_out_last;

    logic [gcou_pkg::STATE_W-1:0]    n_state;

    logic                            in_acc;
    logic                            out_free;
    logic [gcou_pkg::CFG_W-1:0]      w_eff;
    logic [gcou_pkg::CFG_W-1:0]      h_eff;

    logic                            cu_sel_z;
    logic [gcou_pkg::CFG_W-1:0]      cu_size;
    logic signed [gcou_pkg::COORD_W-1:0] cu_c;
    logic signed [gcou_pkg::COORD_W-1:0] cu_h;
    logic signed [gcou_pkg::COORD_W-1:0] cu_off;
    logic signed [gcou_pkg::COORD_W-1:0] cu_sum;
    logic [gcou_pkg::IDX_W-1:0]      cu_idx;
    logic [gcou_pkg::GCOORD_W-1:0]   cu_res;

    logic [gcou_pkg::GCOORD_W-1:0]   cm_x;
    logic [gcou_pkg::GCOORD_W-1:0]   cm_z;
    gcou_pkg::t_cell                 cm_cell;
    logic                            cm_dup;

    logic [gcou_pkg::LIST_LEN-1:0]   mk_leave;
    logic [gcou_pkg::LIST_LEN-1:0]   mk_enter;

    logic [gcou_pkg::EV_IDX_W-1:0]   ev_idx;
    logic [gcou_pkg::EV_W-1:0]       ev_onehot;
    gcou_pkg::t_cell                 ev_cell;
    logic                            ev_last;

    logic                            ent_we;
    logic                            ent_re;
    logic [gcou_pkg::ENT_LIST_W-1:0] ent_wdata;
    logic [gcou_pkg::ENT_LIST_W-1:0] ent_rdata;
    logic                            occ_we;
    logic                            occ_re;
    logic [gcou_pkg::OCC_W-1:0]      occ_wdata;
    logic [gcou_pkg::OCC_W-1:0]      occ_rdata;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_vld || o_out.ready;

    assign i_in.ready        = (r_state == gcou_pkg::S_IDLE);
    assign o_out.valid       = r_out_vld;
    assign o_out.cell_number = r_out_cell;
    assign o_out.entered     = r_out_entered;
    assign o_out.mover_id    = r_out_id;
    assign o_out.last_event  = r_out_last;

    always_comb begin
        if (r_grid_w == '0) begin
            w_eff = gcou_pkg::CFG_W'(1);
        end else if (r_grid_w > gcou_pkg::CFG_W'(gcou_pkg::GRID_MAX)) begin
            w_eff = gcou_pkg::CFG_W'(gcou_pkg::GRID_MAX);
        end else begin
            w_eff = r_grid_w;
        end
        if (r_grid_h == '0) begin
            h_eff = gcou_pkg::CFG_W'(1);
        end else if (r_grid_h > gcou_pkg::CFG_W'(gcou_pkg::GRID_MAX)) begin
            h_eff = gcou_pkg::CFG_W'(gcou_pkg::GRID_MAX);
        end else begin
            h_eff = r_grid_h;
        end
    end

    // Shared coordinate unit: step 0 left, 1 right, 2 top, 3 bottom.
    always_comb begin
        cu_sel_z = r_step[1];
        cu_size  = cu_sel_z ? h_eff : w_eff;
        cu_c     = gcou_pkg::COORD_W'(cu_sel_z ? r_cz : r_cx);
        cu_h     = signed'(gcou_pkg::COORD_W'(cu_sel_z ? r_hz : r_hx));
        cu_off   = signed'(gcou_pkg::COORD_W'(cu_size) << (gcou_pkg::FRAC_BITS - 1));
        if (r_step[0]) begin
            cu_sum = cu_c + cu_off + cu_h - gcou_pkg::COORD_W'(1);
        end else begin
            cu_sum = cu_c + cu_off - cu_h + gcou_pkg::COORD_W'(1);
        end
        cu_idx = cu_sum[gcou_pkg::COORD_W-1:gcou_pkg::FRAC_BITS];
        if (cu_sum[gcou_pkg::COORD_W-1]) begin
            cu_res = '0;
        end else if (cu_idx >= gcou_pkg::IDX_W'(cu_size)) begin
            cu_res = gcou_pkg::GCOORD_W'(cu_size - gcou_pkg::CFG_W'(1));
        end else begin
            cu_res = cu_idx[gcou_pkg::GCOORD_W-1:0];
        end
    end

    // Shared cell unit: corners in the order top-left, top-right, bottom-left, bottom-right.
    always_comb begin
        cm_z    = r_step[1] ? r_coord[3] : r_coord[2];
        cm_x    = r_step[0] ? r_coord[1] : r_coord[0];
        cm_cell = gcou_pkg::CELL_W'(gcou_pkg::MUL_W'(cm_z) * gcou_pkg::MUL_W'(w_eff)
                                    + gcou_pkg::MUL_W'(cm_x));
        cm_dup  = 1'b0;
        for (int i = 0; i < gcou_pkg::LIST_LEN; i++) begin
            if (gcou_pkg::LIST_CNT_W'(i) < r_nn && r_nw[i] == cm_cell) begin
                cm_dup = 1'b1;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < gcou_pkg::LIST_LEN; i++) begin
            mk_leave[i] = gcou_pkg::LIST_CNT_W'(i) < r_old_cnt;
            mk_enter[i] = gcou_pkg::LIST_CNT_W'(i) < r_nn;
            for (int j = 0; j < gcou_pkg::LIST_LEN; j++) begin
                if (gcou_pkg::LIST_CNT_W'(j) < r_nn && r_nw[j] == r_old[i]) begin
                    mk_leave[i] = 1'b0;
                end
                if (gcou_pkg::LIST_CNT_W'(j) < r_old_cnt && r_old[j] == r_nw[i]) begin
                    mk_enter[i] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        ev_idx = '0;
        for (int j = gcou_pkg::EV_W - 1; j >= 0; j--) begin
            if (r_ev_mask[j]) begin
                ev_idx = gcou_pkg::EV_IDX_W'(j);
            end
        end
        ev_onehot = gcou_pkg::EV_W'(1) << ev_idx;
        ev_last   = (r_ev_mask & ~ev_onehot) == '0;
        ev_cell   = ev_idx[gcou_pkg::EV_IDX_W-1] ? r_nw[ev_idx[1:0]] : r_old[ev_idx[1:0]];
    end

    always_comb begin
        ent_wdata = '0;
        ent_wdata[gcou_pkg::ENT_LIST_W-1 -: gcou_pkg::LIST_CNT_W] = r_nn;
        for (int i = 0; i < gcou_pkg::LIST_LEN; i++) begin
            if (gcou_pkg::LIST_CNT_W'(i) < r_nn) begin
                ent_wdata[i*gcou_pkg::CELL_W +: gcou_pkg::CELL_W] = r_nw[i];
            end
        end
        occ_wdata = r_occ_hit ? occ_rdata : '0;
        occ_wdata[r_id] = r_set;
    end

    assign ent_re = in_acc;
    assign ent_we = (r_state == gcou_pkg::S_MASK);
    assign occ_re = (r_state == gcou_pkg::S_EVRD) && out_free;
    assign occ_we = (r_state == gcou_pkg::S_EVWR);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gcou_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = gcou_pkg::S_CALC;
                end
            end
            gcou_pkg::S_CALC: begin
                if (r_step == '1) begin
                    n_state = gcou_pkg::S_MASK;
                end
            end
            gcou_pkg::S_MASK: begin
                n_state = ({mk_enter, mk_leave} == '0) ? gcou_pkg::S_IDLE : gcou_pkg::S_EVRD;
            end
            gcou_pkg::S_EVRD: begin
                if (out_free) begin
                    n_state = gcou_pkg::S_EVWR;
                end
            end
            gcou_pkg::S_EVWR: begin
                n_state = (r_ev_mask == '0) ? gcou_pkg::S_IDLE : gcou_pkg::S_EVRD;
            end
            default: begin
                n_state = gcou_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gcou_pkg::S_IDLE;
            r_step    <= '0;
            r_grid_w  <= gcou_pkg::CFG_W'(gcou_pkg::GRID_MAX);
            r_grid_h  <= gcou_pkg::CFG_W'(gcou_pkg::GRID_MAX);
            r_ent_vld <= '0;
            r_occ_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    gcou_pkg::REG_GRID_WIDTH:  r_grid_w <= i_cfg_data;
                    gcou_pkg::REG_GRID_HEIGHT: r_grid_h <= i_cfg_data;
                endcase
            end
            if (in_acc) begin
                r_step <= '0;
            end else if (r_state == gcou_pkg::S_CALC) begin
                r_step <= r_step + gcou_pkg::STEP_W'(1);
            end
            if (ent_we) begin
                r_ent_vld[r_id] <= 1'b1;
            end
            if (occ_we) begin
                r_occ_vld[r_cell] <= 1'b1;
            end
            if (occ_re) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_id      <= i_in.object_id;
            r_cx      <= i_in.centre_x;
            r_cz      <= i_in.centre_z;
            r_hx      <= i_in.half_extent_x;
            r_hz      <= i_in.half_extent_z;
            r_nn      <= '0;
            r_old_vld <= r_ent_vld[i_in.object_id];
        end
        if (r_state == gcou_pkg::S_CALC) begin
            if (!r_step[2]) begin
                r_coord[r_step[1:0]] <= cu_res;
            end else if (!cm_dup) begin
                r_nw[r_nn[1:0]] <= cm_cell;
                r_nn            <= r_nn + gcou_pkg::LIST_CNT_W'(1);
            end
            if (r_step == '0) begin
                r_old_cnt <= r_old_vld
                    ? ent_rdata[gcou_pkg::ENT_LIST_W-1 -: gcou_pkg::LIST_CNT_W] : '0;
                for (int i = 0; i < gcou_pkg::LIST_LEN; i++) begin
                    r_old[i] <= ent_rdata[i*gcou_pkg::CELL_W +: gcou_pkg::CELL_W];
                end
            end
        end
        if (r_state == gcou_pkg::S_MASK) begin
            r_ev_mask <= {mk_enter, mk_leave};
        end
        if (occ_re) begin
            r_ev_mask     <= r_ev_mask & ~ev_onehot;
            r_cell        <= ev_cell;
            r_set         <= ev_idx[gcou_pkg::EV_IDX_W-1];
            r_occ_hit     <= r_occ_vld[ev_cell];
            r_out_cell    <= ev_cell;
            r_out_entered <= ev_idx[gcou_pkg::EV_IDX_W-1];
            r_out_id      <= r_id;
            r_out_last    <= ev_last;
        end
    end

    gcou_ram #(
        .WIDTH (gcou_pkg::ENT_LIST_W),
        .DEPTH (gcou_pkg::MAX_OBJECTS)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (r_id),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (i_in.object_id),
        .o_rdata (ent_rdata)
    );

    gcou_ram #(
        .WIDTH (gcou_pkg::OCC_W),
        .DEPTH (gcou_pkg::GRID_CELLS)
    ) u_occ_ram (
        .i_clk   (i_clk),
        .i_we    (occ_we),
        .i_waddr (r_cell),
        .i_wdata (occ_wdata),
        .i_re    (occ_re),
        .i_raddr (ev_cell),
        .o_rdata (occ_rdata)
    );

    `GCOU_ASSERT(a_nn_range, i_clk, i_rst_n, (r_state == gcou_pkg::S_MASK) |-> (r_nn != '0 && r_nn <= gcou_pkg::LIST_CNT_W'(gcou_pkg::LIST_LEN)), "new cell count out of range")
    `GCOU_ASSERT(a_ev_pending, i_clk, i_rst_n, (r_state == gcou_pkg::S_EVRD) |-> (r_ev_mask != '0), "event step with no event left")
    `GCOU_ASSERT_NEXT(a_ev_loaded, i_clk, i_rst_n, r_state == gcou_pkg::S_EVRD && out_free, o_out.valid && r_state == gcou_pkg::S_EVWR, "event beat not loaded")
    `GCOU_ASSERT(a_out_src, i_clk, i_rst_n, $rose(o_out.valid) |-> ($past(r_state) == gcou_pkg::S_EVRD), "output beat outside event step")

endmodule
